[design/itoa_pkg.sv]
// Shared types, constants and the digit-to-character function for the radix converter.
package itoa_pkg;

    localparam int VALUE_W        = 32;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 8;
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 32;

    localparam logic [CHAR_W-1:0]  CH_MINUS    = 8'h2D;
    localparam logic [CHAR_W-1:0]  CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_LETTER   = 8'h61;
    localparam logic [RADIX_W-1:0] DEC_RADIX   = 6'd10;
    localparam logic [RADIX_W-1:0] TOP_NUMERAL = 6'd9;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               signed_mode;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } out_word_t;

    // Map a digit value to its lower-case ASCII numeral.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d > TOP_NUMERAL)
        begin
            return d_ext - CHAR_W'(DEC_RADIX) + CH_LETTER;
        end
        return d_ext + CH_ZERO;
    endfunction

endpackage

[design/itoa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module itoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/integer_to_ascii_radix_core.sv]
// Top level of the integer to ASCII radix converter.
//
// Usage: present a word on src_word (value, radix, signed_mode) with
// src_valid; it is taken at a clock edge where src_valid is high and
// src_stall is low. The block then emits the text of the number on
// dst_word, one ASCII character per word, most significant digit first,
// with last set on the final character. A leading '-' appears only for a
// negative value in signed mode and radix 10. Radix is clamped to 2..36.
//
// Timing: one item is in flight at a time; src_stall stays high from
// acceptance until the final character is loaded into the output
// register. Each digit comes out of the bit-serial restoring divider
// (one quotient bit per cycle). Every digit character then passes
// through the digit RAM's registered read port (states S_READ and
// S_LOAD), after a minus sign from S_SIGN when the value is negative.
//
// Reset clears the sequencer and the output valid; the digit RAM is not
// cleared. When the receiver stalls, the output word holds and the
// sequencer waits before loading the next character.
module integer_to_ascii_radix_core #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = itoa_pkg::MAX_DIGITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  itoa_pkg::in_word_t  src_word,
    output logic                dst_valid,
    input  logic                dst_stall,
    output itoa_pkg::out_word_t dst_word
);

    import itoa_pkg::*;

    localparam int BC_W  = $clog2(VALUE_BITS);
    localparam int AW    = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int CP_W  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SIGN = 5'b00100,
        S_READ = 5'b01000,
        S_LOAD = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [RADIX_W-1:0]   r_reg, r_next;
    logic [RADIX_W-1:0]   radix_reg, radix_next;
    logic [BC_W-1:0]      bit_reg, bit_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 neg_reg, neg_next;
    logic                 dst_valid_reg, dst_valid_next;
    out_word_t            dst_word_reg, dst_word_next;

    // Input decode
    logic [VALUE_BITS-1:0] v_in;
    logic [RADIX_W-1:0]    radix_in;
    logic                  neg_in;

    // Divider step
    logic [RADIX_W:0]      trial;
    logic                  ge;
    logic [RADIX_W-1:0]    r_step;
    logic [VALUE_BITS-1:0] q_step;
    logic                  last_bit;

    // RAM hookup
    logic                  wr_en;
    logic [CHAR_W-1:0]     wr_data;
    logic                  rd_en;
    logic [CHAR_W-1:0]     rd_data;
    logic                  out_free;

    itoa_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign src_stall = (state_reg != S_IDLE);
    assign dst_valid = dst_valid_reg;
    assign dst_word  = dst_word_reg;
    assign out_free  = !dst_valid_reg || !dst_stall;

    always_comb
    begin
        v_in = VALUE_BITS'(src_word.value[CP_W-1:0]);
        if (src_word.radix < RADIX_MIN)
        begin
            radix_in = RADIX_MIN;
        end
        else if (src_word.radix > RADIX_MAX)
        begin
            radix_in = RADIX_MAX;
        end
        else
        begin
            radix_in = src_word.radix;
        end
        neg_in = src_word.signed_mode && (radix_in == DEC_RADIX) && v_in[VALUE_BITS-1];
    end

    // One restoring-division step: shift in the next quotient bit.
    always_comb
    begin
        trial    = {r_reg, q_reg[VALUE_BITS-1]};
        ge       = (trial >= {1'b0, radix_reg});
        r_step   = ge ? RADIX_W'(trial - {1'b0, radix_reg}) : RADIX_W'(trial);
        q_step   = {q_reg[VALUE_BITS-2:0], ge};
        last_bit = (bit_reg == BC_W'(VALUE_BITS - 1));
        wr_data  = digit_char(r_step);
    end

    always_comb
    begin
        state_next     = state_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        radix_next     = radix_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        dst_valid_next = dst_valid_reg;
        dst_word_next  = dst_word_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        // Drop the output word once the receiver takes it.
        if (!dst_stall)
        begin
            dst_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (src_valid)
                begin
                    radix_next = radix_in;
                    neg_next   = neg_in;
                    q_next     = neg_in ? (~v_in + VALUE_BITS'(1)) : v_in;
                    r_next     = '0;
                    bit_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                q_next   = q_step;
                r_next   = r_step;
                bit_next = bit_reg + BC_W'(1);
                if (last_bit)
                begin
                    // Digit complete: store it, then divide again or emit.
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    r_next   = '0;
                    bit_next = '0;
                    if ((q_step == '0) || (cnt_reg >= CNT_W'(MAX_DIGITS - 1)))
                    begin
                        idx_next   = cnt_reg[AW-1:0];
                        state_next = neg_reg ? S_SIGN : S_READ;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    dst_valid_next          = 1'b1;
                    dst_word_next.character = CH_MINUS;
                    dst_word_next.last      = 1'b0;
                    state_next              = S_READ;
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    dst_valid_next          = 1'b1;
                    dst_word_next.character = rd_data;
                    dst_word_next.last      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - AW'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    // Datapath registers: hold until the sequencer advances them.
    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        r_reg        <= r_next;
        radix_reg    <= radix_next;
        bit_reg      <= bit_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        neg_reg      <= neg_next;
        dst_word_reg <= dst_word_next;
    end

endmodule

[tb/integer_to_ascii_radix_checker.sv]
// Checker for the radix converter: predicts the text of every accepted number and compares it.
`timescale 1ns / 100ps

module integer_to_ascii_radix_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    input  logic                src_stall,
    input  itoa_pkg::in_word_t  src_word,
    input  logic                dst_valid,
    input  logic                dst_stall,
    input  itoa_pkg::out_word_t dst_word,
    output int                  fail_count,
    output int                  pending_count
);

    import itoa_pkg::*;

    out_word_t text_q [$];
    int        mismatches;

    // Append the characters that the block must print for one number.
    function automatic void predict_text(input in_word_t w);
        logic [RADIX_W-1:0] base;
        logic [VALUE_W-1:0] mag;
        logic [RADIX_W-1:0] d;
        logic [CHAR_W-1:0]  digits [$];
        out_word_t          c;
        base = w.radix;
        if (base < RADIX_MIN)
        begin
            base = RADIX_MIN;
        end
        else if (base > RADIX_MAX)
        begin
            base = RADIX_MAX;
        end
        mag = w.value;
        if (w.signed_mode && base == DEC_RADIX && w.value[VALUE_W-1])
        begin
            mag = -w.value;
            c.character = CH_MINUS;
            c.last      = 1'b0;
            text_q.push_back(c);
        end
        // Peel off digits least significant first, store them reversed.
        do
        begin
            d   = RADIX_W'(mag % VALUE_W'(base));
            mag = mag / VALUE_W'(base);
            if (d > TOP_NUMERAL)
            begin
                digits.push_front(CH_LETTER + CHAR_W'(d) - CHAR_W'(DEC_RADIX));
            end
            else
            begin
                digits.push_front(CH_ZERO + CHAR_W'(d));
            end
        end
        while (mag != 0 && digits.size() < MAX_DIGITS_DEF);
        foreach (digits[i])
        begin
            c.character = digits[i];
            c.last      = (i == digits.size() - 1);
            text_q.push_back(c);
        end
    endfunction

    // Compare one taken word with the oldest outstanding character.
    function automatic void check_character(input out_word_t got);
        out_word_t want;
        if (text_q.size() == 0)
        begin
            $error("unexpected word: character %h last %b", got.character, got.last);
            mismatches++;
            return;
        end
        want = text_q.pop_front();
        if (got.character !== want.character)
        begin
            $error("character: expected %h, got %h", want.character, got.character);
            mismatches++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %b, got %b", want.last, got.last);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_q.delete();
            mismatches = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (dst_valid && !dst_stall)
            begin
                check_character(dst_word);
            end
            if (src_valid && !src_stall)
            begin
                predict_text(src_word);
            end
            pending_count <= text_q.size();
            fail_count    <= mismatches;
        end
    end

endmodule

[tb/integer_to_ascii_radix_core_tb.sv]
// Top of the radix converter testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module integer_to_ascii_radix_core_tb;

    import itoa_pkg::*;

    localparam int STALL_MAX       = 13;     // longest random per-word wait on either side
    localparam int RANDOM_NUMBERS  = 80;
    localparam int HOLD_OFF_AFTER  = 250;    // characters taken before the long output hold-off
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int WATCHDOG_LIMIT  = 10000;  // cycles with no word moving on either channel
    localparam int DRAIN_CYCLES    = 80;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      src_valid = 1'b0;
    in_word_t  src_word  = '0;
    logic      dst_stall = 1'b0;
    logic      src_stall;
    logic      dst_valid;
    out_word_t dst_word;

    int fail_count;
    int pending_count;
    int numbers_sent    = 0;
    int negatives_sent  = 0;
    int chars_taken     = 0;
    int idle_cycles     = 0;

    // Directed numbers: field extremes, radixes clamped from both sides, the sign rules
    // and the most negative value.
    in_word_t directed_words [22] = '{
        {32'h0000_0000, DEC_RADIX, 1'b0},   // zero prints a single digit
        {32'h0000_0000, DEC_RADIX, 1'b1},
        {32'hFFFF_FFFF, RADIX_MIN, 1'b0},   // longest text: 32 binary ones
        {32'hFFFF_FFFF, DEC_RADIX, 1'b1},   // minus one
        {32'hFFFF_FFFF, DEC_RADIX, 1'b0},
        {32'hFFFF_FFFF, 6'd16,     1'b1},   // signed flag has no effect outside decimal
        {32'hFFFF_FFFF, RADIX_MAX, 1'b0},
        {32'h8000_0000, DEC_RADIX, 1'b1},   // most negative value
        {32'h7FFF_FFFF, DEC_RADIX, 1'b1},
        {32'h8000_0000, RADIX_MIN, 1'b1},
        {32'h0000_3039, 6'd0,      1'b0},   // radix below two saturates
        {32'h0000_3039, 6'd1,      1'b1},
        {32'h0000_3039, 6'd37,     1'b0},   // radix above thirty-six saturates
        {32'h0000_3039, 6'd63,     1'b1},
        {32'h0000_0023, RADIX_MAX, 1'b0},   // highest letter digit
        {32'h0000_000A, 6'd11,     1'b0},   // lowest letter digit
        {32'h0000_0009, DEC_RADIX, 1'b1},   // highest numeral digit
        {32'hDEAD_BEEF, 6'd16,     1'b0},
        {32'h0123_4567, 6'd8,      1'b0},
        {32'hFFFF_FFFE, 6'd3,      1'b1},
        {32'h5555_5555, 6'd35,     1'b1},
        {32'h8000_0001, DEC_RADIX, 1'b1}
    };

    integer_to_ascii_radix_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word)
    );

    integer_to_ascii_radix_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .src_word      (src_word),
        .dst_valid     (dst_valid),
        .dst_stall     (dst_stall),
        .dst_word      (dst_word),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Offer one number and hold it until the block takes it. Every third run
    // of ten numbers goes out back to back, the rest after a random gap.
    task automatic offer_number(input in_word_t w);
        int gap;
        gap = (((numbers_sent / 10) % 3) == 2) ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word  <= w;
        @(posedge clk);
        while (src_stall)
        begin
            @(posedge clk);
        end
        numbers_sent++;
        if (w.signed_mode && w.radix == DEC_RADIX && w.value[VALUE_W-1])
        begin
            negatives_sent++;
        end
    endtask

    // Sender: directed numbers, a pause until all text is out, then random numbers.
    initial
    begin
        in_word_t w;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[i])
        begin
            offer_number(directed_words[i]);
        end

        // Drop valid and wait for every outstanding character.
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end

        for (int k = 0; k < RANDOM_NUMBERS; k++)
        begin
            // Mix full-range values with short ones and values near the extremes.
            case ($urandom_range(0, 3))
                0:       w.value = $urandom_range(0, 255);
                1:       w.value = 32'hFFFF_FFFF - $urandom_range(0, 15);
                2:       w.value = 32'h8000_0000 + $urandom_range(0, 15);
                default: w.value = $urandom;
            endcase
            // Favour decimal so the sign path gets plenty of traffic; now and
            // then use the whole radix field, out-of-range codes included.
            case ($urandom_range(0, 4))
                0:       w.radix = RADIX_W'($urandom_range(0, 63));
                1:       w.radix = DEC_RADIX;
                2:       w.radix = DEC_RADIX;
                default: w.radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
            endcase
            w.signed_mode = 1'($urandom_range(0, 1));
            offer_number(w);
        end
        src_valid <= 1'b0;

        // Wait for the tail of the text, then let stray words show up.
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d numbers (%0d negative decimals) and checked %0d characters,",
                 numbers_sent, negatives_sent, chars_taken);
        $display("covering clamped radixes, both sign modes and the longest binary text.");
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver: stall a random number of cycles before each word, with quiet
    // stretches, and once hold off for a long time so the block backs up.
    initial
    begin
        int  hold;
        bit  quiet;
        bit  held_off;
        held_off = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            quiet = ((chars_taken / 40) % 3) == 1;
            if (!held_off && chars_taken >= HOLD_OFF_AFTER)
            begin
                held_off = 1'b1;
                hold     = HOLD_OFF_CYCLES;
            end
            else
            begin
                hold = quiet ? 0 : $urandom_range(0, STALL_MAX);
            end
            if (hold > 0)
            begin
                dst_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            dst_stall <= 1'b0;
            @(posedge clk);
            while (!dst_valid)
            begin
                @(posedge clk);
            end
            chars_taken++;
        end
    end

    // Watchdog: advance while no word moves on either channel, clear on any move.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no word moved for %0d cycles, %0d characters outstanding",
                       idle_cycles, pending_count);
                $display("FAILURE");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
